// ===== src/rsnh_pkg.sv =====
// Shared types, widths and codes of the ray and sphere nearest-hit unit.
`default_nettype none

package rsnh_pkg;

    // Fixed-point format of coordinates: signed Q2.14.
    localparam int FRAC_BITS  = 14;
    localparam int COORD_W    = 16;
    localparam int RADIUS_W   = 15;
    localparam int COLOR_W    = 8;
    localparam int SLOT_W     = 3;
    localparam int PIX_X_W    = 10;
    localparam int PIX_Y_W    = 9;
    localparam int INDEX_W    = 3;
    localparam int HIT_DIST_W = 16;

    // Sphere table words.
    localparam int GEOM_W = 64;
    localparam int RGB_W  = 3 * COLOR_W;

    // Internal datapath widths, sized for the worst image height.
    localparam int MUL_W     = 26;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int ACC_W     = 56;
    localparam int DIR_W     = 16;
    localparam int OFS_W     = COORD_W + 1;
    localparam int DIV_NUM_W = 40;
    localparam int DIV_DEN_W = 26;
    localparam int ROOT_IN_W = ACC_W;
    localparam int ROOT_W    = ROOT_IN_W / 2;
    localparam int DIST_W    = 30;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int ACTIVE_W    = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_EYE_X  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EYE_Y  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EYE_Z  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE = 2'd3;

    localparam logic signed [COORD_W-1:0] EYE_X_RST  = 16'sd8192;
    localparam logic signed [COORD_W-1:0] EYE_Y_RST  = 16'sd8192;
    localparam logic signed [COORD_W-1:0] EYE_Z_RST  = -16'sd16384;
    localparam logic [ACTIVE_W-1:0]       ACTIVE_RST = 4'd3;

    // Operation codes of an input word.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TRACE = 1'b1;

    typedef struct packed {
        logic                        operation;
        logic [SLOT_W-1:0]           sphere_slot;
        logic signed [COORD_W-1:0]   center_x;
        logic signed [COORD_W-1:0]   center_y;
        logic signed [COORD_W-1:0]   center_z;
        logic [RADIUS_W-1:0]         radius;
        logic [COLOR_W-1:0]          color_red;
        logic [COLOR_W-1:0]          color_green;
        logic [COLOR_W-1:0]          color_blue;
        logic [PIX_X_W-1:0]          pixel_x;
        logic [PIX_Y_W-1:0]          pixel_y;
    } in_word_t;

    typedef struct packed {
        logic [COLOR_W-1:0]    pixel_red;
        logic [COLOR_W-1:0]    pixel_green;
        logic [COLOR_W-1:0]    pixel_blue;
        logic                  sphere_hit;
        logic [INDEX_W-1:0]    hit_index;
        logic [HIT_DIST_W-1:0] hit_distance;
    } out_word_t;

    typedef struct packed {
        logic                        start;
        logic signed [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0]        den;
    } div_req_t;

    typedef struct packed {
        logic                        done;
        logic signed [DIV_NUM_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic                 start;
        logic [ROOT_IN_W-1:0] radicand;
    } root_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } root_rsp_t;

endpackage

`default_nettype wire

// ===== src/rsnh_sphere_mem.sv =====
// Sphere table: geometry and colour memories with registered reads.
`default_nettype none

module rsnh_sphere_mem #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [rsnh_pkg::GEOM_W-1:0]  wr_geom,
    input  logic [rsnh_pkg::RGB_W-1:0]   wr_rgb,
    input  logic                         geom_rd_en,
    input  logic [ADDR_W-1:0]            geom_rd_addr,
    output logic [rsnh_pkg::GEOM_W-1:0]  geom_rd,
    input  logic                         rgb_rd_en,
    input  logic [ADDR_W-1:0]            rgb_rd_addr,
    output logic [rsnh_pkg::RGB_W-1:0]   rgb_rd
);

    logic [rsnh_pkg::GEOM_W-1:0] geom_mem [DEPTH];
    logic [rsnh_pkg::RGB_W-1:0]  rgb_mem  [DEPTH];
    logic [rsnh_pkg::GEOM_W-1:0] geom_rd_reg;
    logic [rsnh_pkg::RGB_W-1:0]  rgb_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            geom_mem[wr_addr] <= wr_geom;
            rgb_mem[wr_addr]  <= wr_rgb;
        end
        if (geom_rd_en)
        begin
            geom_rd_reg <= geom_mem[geom_rd_addr];
        end
        if (rgb_rd_en)
        begin
            rgb_rd_reg <= rgb_mem[rgb_rd_addr];
        end
    end

    assign geom_rd = geom_rd_reg;
    assign rgb_rd  = rgb_rd_reg;

endmodule

`default_nettype wire

// ===== src/rsnh_divider.sv =====
// Serial restoring divider that rounds to nearest with halves away from zero.
`default_nettype none

module rsnh_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  rsnh_pkg::div_req_t req,
    output rsnh_pkg::div_rsp_t rsp
);

    localparam int NUM_W = rsnh_pkg::DIV_NUM_W;
    localparam int DEN_W = rsnh_pkg::DIV_DEN_W;
    localparam int CNT_W = $clog2(NUM_W);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [NUM_W-1:0]        quo_reg, quo_next;
    logic [DEN_W-1:0]        rem_reg, rem_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic                    neg_reg, neg_next;
    logic signed [NUM_W-1:0] res_reg, res_next;

    logic [NUM_W-1:0] num_mag;
    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   rem_diff;
    logic             fits;
    logic [NUM_W-1:0] quo_step;

    always_comb
    begin
        num_mag   = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
        rem_shift = {rem_reg, quo_reg[NUM_W-1]};
        rem_diff  = rem_shift - {1'b0, den_reg};
        fits      = (rem_shift >= {1'b0, den_reg});
        quo_step  = {quo_reg[NUM_W-2:0], fits};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        res_next  = res_reg;

        if (busy_reg)
        begin
            quo_next = quo_step;
            rem_next = fits ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = neg_reg ? -$signed(quo_step) : $signed(quo_step);
            end
        end
        else if (req.start)
        begin
            // Adding half the divisor first turns truncation into rounding.
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = num_mag + NUM_W'(req.den >> 1);
            rem_next  = '0;
            den_next  = req.den;
            neg_next  = req.num[NUM_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = res_reg;

endmodule

`default_nettype wire

// ===== src/rsnh_isqrt.sv =====
// Serial floor integer square root, one result bit per cycle.
`default_nettype none

module rsnh_isqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  rsnh_pkg::root_req_t req,
    output rsnh_pkg::root_rsp_t rsp
);

    localparam int IN_W  = rsnh_pkg::ROOT_IN_W;
    localparam int OUT_W = rsnh_pkg::ROOT_W;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [IN_W-1:0]   val_reg, val_next;
    logic [IN_W-1:0]   acc_reg, acc_next;
    logic [IN_W-1:0]   bit_reg, bit_next;
    logic [OUT_W-1:0]  root_reg, root_next;

    logic [IN_W-1:0] trial;
    logic            fits;
    logic [IN_W-1:0] acc_step;

    always_comb
    begin
        trial    = acc_reg + bit_reg;
        fits     = (val_reg >= trial);
        acc_step = fits ? ((acc_reg >> 1) + bit_reg) : (acc_reg >> 1);

        busy_next = busy_reg;
        done_next = 1'b0;
        val_next  = val_reg;
        acc_next  = acc_reg;
        bit_next  = bit_reg;
        root_next = root_reg;

        if (busy_reg)
        begin
            val_next = fits ? (val_reg - trial) : val_reg;
            acc_next = acc_step;
            bit_next = bit_reg >> 2;
            // The trial bit reaching the least significant place is the last step.
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                root_next = acc_step[OUT_W-1:0];
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            val_next  = req.radicand;
            acc_next  = '0;
            bit_next  = {2'b01, {(IN_W-2){1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        acc_reg  <= acc_next;
        bit_reg  <= bit_next;
        root_reg <= root_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

`default_nettype wire

// ===== src/ray_sphere_nearest_hit_unit.sv =====
// A sphere write word gives no result. A pixel result is registered once the ray length
// root, the three serial divisions of the direction and, for each active sphere, a
// projection and a discriminant have been worked out, with a square root only when the
// discriminant is not negative; a zero-length ray skips the divisions.
// Throughput: one pixel at a time; the next word is taken once the result is registered.
// Reset: eye at (0.5, 0.5, -1.0), three active spheres, no result pending; table not cleared.
`default_nettype none

// Top level of the ray and sphere nearest-hit unit.
module ray_sphere_nearest_hit_unit #(
    parameter int MAX_SPHERES  = 8,
    parameter int IMAGE_HEIGHT = 480
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  rsnh_pkg::in_word_t                    in_word,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output rsnh_pkg::out_word_t                   out_word,
    input  logic                                  cfg_we,
    input  logic [rsnh_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [rsnh_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int ADDR_W    = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int CNT_W     = ADDR_W + 1;
    localparam int MUL_W     = rsnh_pkg::MUL_W;
    localparam int PROD_W    = rsnh_pkg::PROD_W;
    localparam int ACC_W     = rsnh_pkg::ACC_W;
    localparam int DIR_W     = rsnh_pkg::DIR_W;
    localparam int OFS_W     = rsnh_pkg::OFS_W;
    localparam int NUM_W     = rsnh_pkg::DIV_NUM_W;
    localparam int DEN_W     = rsnh_pkg::DIV_DEN_W;
    localparam int DIST_W    = rsnh_pkg::DIST_W;
    localparam int COORD_W   = rsnh_pkg::COORD_W;
    localparam int FRAC_BITS = rsnh_pkg::FRAC_BITS;
    localparam int INDEX_W   = rsnh_pkg::INDEX_W;
    localparam int PIX_X_W   = rsnh_pkg::PIX_X_W;

    localparam int COLOR_W_LOCAL = rsnh_pkg::COLOR_W;

    // The image-plane coordinate (2p + 1) / (2 * height) is a division by a constant,
    // done as a multiplication by a rounded-up reciprocal that is exact for every
    // numerator below 2^PIX_NUM_W.
    localparam int PIX_DEN_I = 2 * IMAGE_HEIGHT;
    localparam int PIX_NUM_W = PIX_X_W + 1 + FRAC_BITS;
    localparam int PIX_SHIFT = PIX_NUM_W + $clog2(PIX_DEN_I);
    localparam int RECIP_W   = PIX_NUM_W + 2;
    localparam int PIX_PRD_W = PIX_NUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0]   PIX_RECIP = RECIP_W'(((64'd1 << PIX_SHIFT) +
                                                 64'(PIX_DEN_I) - 64'd1) / 64'(PIX_DEN_I));
    localparam logic [PIX_NUM_W-1:0] PIX_HALF  = PIX_NUM_W'(IMAGE_HEIGHT);

    localparam logic signed [MUL_W-1:0] ONE_FIX  = MUL_W'(1 << FRAC_BITS);
    localparam logic [ACC_W-1:0]        HALF_LSB = ACC_W'(1 << (FRAC_BITS - 1));
    localparam logic [DIST_W-1:0]       DIST_MAX = DIST_W'(16'hFFFF);

    // Sequencer states.
    localparam logic [4:0] ST_IDLE      = 5'd0;
    localparam logic [4:0] ST_PX_CALC   = 5'd1;
    localparam logic [4:0] ST_PY_CALC   = 5'd2;
    localparam logic [4:0] ST_LEN_MAC   = 5'd3;
    localparam logic [4:0] ST_LEN_ROOT  = 5'd4;
    localparam logic [4:0] ST_LEN_WAIT  = 5'd5;
    localparam logic [4:0] ST_DX_WAIT   = 5'd6;
    localparam logic [4:0] ST_DY_WAIT   = 5'd7;
    localparam logic [4:0] ST_DZ_WAIT   = 5'd8;
    localparam logic [4:0] ST_SPH_BEGIN = 5'd9;
    localparam logic [4:0] ST_SPH_LOAD  = 5'd10;
    localparam logic [4:0] ST_DOT_MAC   = 5'd11;
    localparam logic [4:0] ST_H_CALC    = 5'd12;
    localparam logic [4:0] ST_DISC_MAC  = 5'd13;
    localparam logic [4:0] ST_DISC_CHK  = 5'd14;
    localparam logic [4:0] ST_DISC_WAIT = 5'd15;
    localparam logic [4:0] ST_COL_RD    = 5'd16;
    localparam logic [4:0] ST_OUT       = 5'd17;

    // Control registers.
    logic [4:0]                     state_reg, state_next;
    logic signed [COORD_W-1:0]      eye_x_reg, eye_x_next;
    logic signed [COORD_W-1:0]      eye_y_reg, eye_y_next;
    logic signed [COORD_W-1:0]      eye_z_reg, eye_z_next;
    logic [rsnh_pkg::ACTIVE_W-1:0]  active_reg, active_next;
    logic                           out_valid_reg, out_valid_next;
    logic [2:0]                     mac_step_reg, mac_step_next;
    logic [CNT_W-1:0]               k_reg, k_next;
    logic [CNT_W-1:0]               n_reg, n_next;
    logic                           found_reg, found_next;

    // Datapath registers.
    logic [PIX_X_W-1:0]             x_reg, x_next;
    logic [rsnh_pkg::PIX_Y_W-1:0]   y_reg, y_next;
    logic signed [MUL_W-1:0]        rx_reg, rx_next;
    logic signed [MUL_W-1:0]        ry_reg, ry_next;
    logic signed [MUL_W-1:0]        rz_reg, rz_next;
    logic [DEN_W-1:0]               len_reg, len_next;
    logic signed [DIR_W-1:0]        dx_reg, dx_next;
    logic signed [DIR_W-1:0]        dy_reg, dy_next;
    logic signed [DIR_W-1:0]        dz_reg, dz_next;
    logic signed [OFS_W-1:0]        ox_reg, ox_next;
    logic signed [OFS_W-1:0]        oy_reg, oy_next;
    logic signed [OFS_W-1:0]        oz_reg, oz_next;
    logic [rsnh_pkg::RADIUS_W-1:0]  r_reg, r_next;
    logic signed [MUL_W-1:0]        h_reg, h_next;
    logic signed [PROD_W-1:0]       prod_reg, prod_next;
    logic signed [ACC_W-1:0]        acc_reg, acc_next;
    logic [CNT_W-1:0]               best_k_reg, best_k_next;
    logic signed [DIST_W-1:0]       best_t_reg, best_t_next;
    rsnh_pkg::out_word_t            out_word_reg, out_word_next;

    // Unit handshakes and memory ports.
    rsnh_pkg::div_req_t  div_req;
    rsnh_pkg::div_rsp_t  div_rsp;
    rsnh_pkg::root_req_t root_req;
    rsnh_pkg::root_rsp_t root_rsp;

    logic                          mem_wr_en;
    logic [ADDR_W-1:0]             mem_wr_addr;
    logic [rsnh_pkg::GEOM_W-1:0]   mem_wr_geom;
    logic [rsnh_pkg::RGB_W-1:0]    mem_wr_rgb;
    logic                          geom_rd_en;
    logic [rsnh_pkg::GEOM_W-1:0]   geom_rd;
    logic                          rgb_rd_en;
    logic [rsnh_pkg::RGB_W-1:0]    rgb_rd;

    // Combinational helpers.
    logic                          in_take;
    logic                          out_free;
    logic [2:0]                    mac_last;
    logic signed [MUL_W-1:0]       op_a, op_b;
    logic signed [MUL_W-1:0]       ox_ext, oy_ext, oz_ext, r_ext;
    logic [ACC_W-1:0]              acc_mag;
    logic [ACC_W-1:0]              h_mag;
    logic signed [DIST_W-1:0]      neg_h, root_ext, t_near, t_far, t_sel;
    logic signed [COORD_W-1:0]     cen_x, cen_y, cen_z;
    logic [COLOR_W_LOCAL-1:0]      shade;
    logic [PIX_X_W-1:0]            pix_sel;
    logic [PIX_NUM_W-1:0]          pix_num;
    logic [PIX_PRD_W-1:0]          pix_prod;
    logic signed [MUL_W-1:0]       pix_quot;

    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Fields of the geometry word just read from the table.
    assign cen_x = geom_rd[15:0];
    assign cen_y = geom_rd[31:16];
    assign cen_z = geom_rd[47:32];

    assign ox_ext = MUL_W'(ox_reg);
    assign oy_ext = MUL_W'(oy_reg);
    assign oz_ext = MUL_W'(oz_reg);
    assign r_ext  = MUL_W'(r_reg);

    // Image-plane coordinate of the pixel column in the x step and of the row in the
    // y step, rounded to nearest.
    always_comb
    begin
        pix_sel  = (state_reg == ST_PX_CALC) ? x_reg : PIX_X_W'(y_reg);
        pix_num  = (PIX_NUM_W'({pix_sel, 1'b1}) << FRAC_BITS) + PIX_HALF;
        pix_prod = PIX_PRD_W'(pix_num) * PIX_PRD_W'(PIX_RECIP);
        pix_quot = MUL_W'(pix_prod >> PIX_SHIFT);
    end

    // The multiply-accumulate runs three products for the ray length and the
    // projection, and five for the discriminant h*h - |o|^2 + r^2, whose
    // subtracted terms are fed with one operand negated.
    always_comb
    begin
        mac_last = (state_reg == ST_DISC_MAC) ? 3'd5 : 3'd3;
        op_a     = '0;
        op_b     = '0;
        case (state_reg)
            ST_LEN_MAC:
            begin
                case (mac_step_reg)
                    3'd0:    begin op_a = rx_reg; op_b = rx_reg; end
                    3'd1:    begin op_a = ry_reg; op_b = ry_reg; end
                    default: begin op_a = rz_reg; op_b = rz_reg; end
                endcase
            end
            ST_DOT_MAC:
            begin
                case (mac_step_reg)
                    3'd0:    begin op_a = MUL_W'(dx_reg); op_b = ox_ext; end
                    3'd1:    begin op_a = MUL_W'(dy_reg); op_b = oy_ext; end
                    default: begin op_a = MUL_W'(dz_reg); op_b = oz_ext; end
                endcase
            end
            ST_DISC_MAC:
            begin
                case (mac_step_reg)
                    3'd0:    begin op_a = h_reg;   op_b = h_reg;  end
                    3'd1:    begin op_a = -ox_ext; op_b = ox_ext; end
                    3'd2:    begin op_a = -oy_ext; op_b = oy_ext; end
                    3'd3:    begin op_a = -oz_ext; op_b = oz_ext; end
                    default: begin op_a = r_ext;   op_b = r_ext;  end
                endcase
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Rounded projection h and the two candidate hit distances.
    always_comb
    begin
        acc_mag  = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        h_mag    = (acc_mag + HALF_LSB) >> FRAC_BITS;
        neg_h    = -DIST_W'(h_reg);
        root_ext = DIST_W'(root_rsp.root);
        t_near   = neg_h - root_ext;
        t_far    = neg_h + root_ext;
        t_sel    = t_near[DIST_W-1] ? t_far : t_near;
        shade    = ry_reg[MUL_W-1] ? 8'hFF : 8'h00;
    end

    // Main sequencer.
    always_comb
    begin
        state_next     = state_reg;
        eye_x_next     = eye_x_reg;
        eye_y_next     = eye_y_reg;
        eye_z_next     = eye_z_reg;
        active_next    = active_reg;
        out_valid_next = out_valid_reg;
        mac_step_next  = mac_step_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        found_next     = found_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        rz_next        = rz_reg;
        len_next       = len_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        dz_next        = dz_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        oz_next        = oz_reg;
        r_next         = r_reg;
        h_next         = h_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        best_k_next    = best_k_reg;
        best_t_next    = best_t_reg;
        out_word_next  = out_word_reg;

        div_req        = '0;
        root_req       = '0;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = ADDR_W'(in_word.sphere_slot);
        mem_wr_geom    = {1'b0, in_word.radius, in_word.center_z,
                          in_word.center_y, in_word.center_x};
        mem_wr_rgb     = {in_word.color_red, in_word.color_green, in_word.color_blue};
        geom_rd_en     = 1'b0;
        rgb_rd_en      = 1'b0;

        // The result register empties as soon as the consumer takes it.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // Configuration must be written only while no pixel is in flight; the block itself does not enforce this.
        if (cfg_we)
        begin
            case (cfg_index)
                rsnh_pkg::CFG_EYE_X:  eye_x_next  = cfg_data;
                rsnh_pkg::CFG_EYE_Y:  eye_y_next  = cfg_data;
                rsnh_pkg::CFG_EYE_Z:  eye_z_next  = cfg_data;
                rsnh_pkg::CFG_ACTIVE: active_next = cfg_data[rsnh_pkg::ACTIVE_W-1:0];
                default:              active_next = active_reg;
            endcase
        end

        // Shared multiply-accumulate: each product is registered in prod_reg and then
        // added into acc_reg, so the sum is ready on the step after the last product.
        if (state_reg == ST_LEN_MAC || state_reg == ST_DOT_MAC ||
            state_reg == ST_DISC_MAC)
        begin
            prod_next     = op_a * op_b;
            acc_next      = (mac_step_reg == 3'd0) ? '0 :
                            acc_reg + ACC_W'(prod_reg);
            mac_step_next = mac_step_reg + 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (in_word.operation == rsnh_pkg::OP_TRACE)
                    begin
                        x_next     = in_word.pixel_x;
                        y_next     = in_word.pixel_y;
                        state_next = ST_PX_CALC;
                    end
                    else if (int'(in_word.sphere_slot) < MAX_SPHERES)
                    begin
                        mem_wr_en = 1'b1;
                    end
                end
            end

            ST_PX_CALC:
            begin
                rx_next    = pix_quot - MUL_W'(eye_x_reg);
                state_next = ST_PY_CALC;
            end

            ST_PY_CALC:
            begin
                ry_next       = ONE_FIX - pix_quot - MUL_W'(eye_y_reg);
                rz_next       = -MUL_W'(eye_z_reg);
                n_next        = (int'(active_reg) > MAX_SPHERES) ?
                                CNT_W'(MAX_SPHERES) : CNT_W'(active_reg);
                k_next        = '0;
                found_next    = 1'b0;
                best_k_next   = '0;
                best_t_next   = '0;
                mac_step_next = 3'd0;
                state_next    = ST_LEN_MAC;
            end

            ST_LEN_MAC:
            begin
                if (mac_step_reg == mac_last)
                begin
                    mac_step_next = 3'd0;
                    state_next    = ST_LEN_ROOT;
                end
            end

            ST_LEN_ROOT:
            begin
                root_req.start    = 1'b1;
                root_req.radicand = acc_reg;
                state_next        = ST_LEN_WAIT;
            end

            ST_LEN_WAIT:
            begin
                if (root_rsp.done)
                begin
                    len_next = DEN_W'(root_rsp.root);
                    if (root_rsp.root == '0)
                    begin
                        // A zero-length ray has no direction at all.
                        dx_next    = '0;
                        dy_next    = '0;
                        dz_next    = '0;
                        state_next = ST_SPH_BEGIN;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        div_req.num   = NUM_W'(rx_reg) <<< FRAC_BITS;
                        div_req.den   = DEN_W'(root_rsp.root);
                        state_next    = ST_DX_WAIT;
                    end
                end
            end

            ST_DX_WAIT:
            begin
                if (div_rsp.done)
                begin
                    dx_next       = DIR_W'(div_rsp.quot);
                    div_req.start = 1'b1;
                    div_req.num   = NUM_W'(ry_reg) <<< FRAC_BITS;
                    div_req.den   = len_reg;
                    state_next    = ST_DY_WAIT;
                end
            end

            ST_DY_WAIT:
            begin
                if (div_rsp.done)
                begin
                    dy_next       = DIR_W'(div_rsp.quot);
                    div_req.start = 1'b1;
                    div_req.num   = NUM_W'(rz_reg) <<< FRAC_BITS;
                    div_req.den   = len_reg;
                    state_next    = ST_DZ_WAIT;
                end
            end

            ST_DZ_WAIT:
            begin
                if (div_rsp.done)
                begin
                    dz_next    = DIR_W'(div_rsp.quot);
                    state_next = ST_SPH_BEGIN;
                end
            end

            ST_SPH_BEGIN:
            begin
                if (k_reg == n_reg)
                begin
                    state_next = ST_COL_RD;
                end
                else
                begin
                    geom_rd_en = 1'b1;
                    state_next = ST_SPH_LOAD;
                end
            end

            ST_SPH_LOAD:
            begin
                ox_next       = OFS_W'(eye_x_reg) - OFS_W'(cen_x);
                oy_next       = OFS_W'(eye_y_reg) - OFS_W'(cen_y);
                oz_next       = OFS_W'(eye_z_reg) - OFS_W'(cen_z);
                r_next        = geom_rd[62:48];
                mac_step_next = 3'd0;
                state_next    = ST_DOT_MAC;
            end

            ST_DOT_MAC:
            begin
                if (mac_step_reg == mac_last)
                begin
                    mac_step_next = 3'd0;
                    state_next    = ST_H_CALC;
                end
            end

            ST_H_CALC:
            begin
                h_next     = acc_reg[ACC_W-1] ? -MUL_W'(h_mag) : MUL_W'(h_mag);
                state_next = ST_DISC_MAC;
            end

            ST_DISC_MAC:
            begin
                if (mac_step_reg == mac_last)
                begin
                    mac_step_next = 3'd0;
                    state_next    = ST_DISC_CHK;
                end
            end

            ST_DISC_CHK:
            begin
                if (acc_reg[ACC_W-1])
                begin
                    // The ray passes this sphere by.
                    k_next     = k_reg + 1'b1;
                    state_next = ST_SPH_BEGIN;
                end
                else
                begin
                    root_req.start    = 1'b1;
                    root_req.radicand = acc_reg;
                    state_next        = ST_DISC_WAIT;
                end
            end

            ST_DISC_WAIT:
            begin
                if (root_rsp.done)
                begin
                    // The nearer root wins unless it lies behind the eye; a strict
                    // compare keeps the lower index on equal distances.
                    if (!t_sel[DIST_W-1] && (!found_reg || t_sel < best_t_reg))
                    begin
                        found_next  = 1'b1;
                        best_t_next = t_sel;
                        best_k_next = k_reg;
                    end
                    k_next     = k_reg + 1'b1;
                    state_next = ST_SPH_BEGIN;
                end
            end

            ST_COL_RD:
            begin
                rgb_rd_en  = 1'b1;
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                if (out_free)
                begin
                    if (found_reg)
                    begin
                        out_word_next.pixel_red    = rgb_rd[23:16];
                        out_word_next.pixel_green  = rgb_rd[15:8];
                        out_word_next.pixel_blue   = rgb_rd[7:0];
                        out_word_next.sphere_hit   = 1'b1;
                        out_word_next.hit_index    = INDEX_W'(best_k_reg);
                        out_word_next.hit_distance = (best_t_reg > $signed(DIST_MAX)) ?
                                                     16'hFFFF : best_t_reg[15:0];
                    end
                    else
                    begin
                        // Background: black when the ray is level or rising.
                        out_word_next.pixel_red    = shade;
                        out_word_next.pixel_green  = shade;
                        out_word_next.pixel_blue   = shade;
                        out_word_next.sphere_hit   = 1'b0;
                        out_word_next.hit_index    = '0;
                        out_word_next.hit_distance = '0;
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            eye_x_reg     <= rsnh_pkg::EYE_X_RST;
            eye_y_reg     <= rsnh_pkg::EYE_Y_RST;
            eye_z_reg     <= rsnh_pkg::EYE_Z_RST;
            active_reg    <= rsnh_pkg::ACTIVE_RST;
            out_valid_reg <= 1'b0;
            mac_step_reg  <= '0;
            k_reg         <= '0;
            n_reg         <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            eye_x_reg     <= eye_x_next;
            eye_y_reg     <= eye_y_next;
            eye_z_reg     <= eye_z_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            mac_step_reg  <= mac_step_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        rx_reg       <= rx_next;
        ry_reg       <= ry_next;
        rz_reg       <= rz_next;
        len_reg      <= len_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        dz_reg       <= dz_next;
        ox_reg       <= ox_next;
        oy_reg       <= oy_next;
        oz_reg       <= oz_next;
        r_reg        <= r_next;
        h_reg        <= h_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        best_k_reg   <= best_k_next;
        best_t_reg   <= best_t_next;
        out_word_reg <= out_word_next;
    end

    // Words are taken only between pixels; the result register keeps the last
    // result on offer while the next word is being accepted.
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    rsnh_sphere_mem #(
        .DEPTH  (MAX_SPHERES),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk          (clk),
        .wr_en        (mem_wr_en),
        .wr_addr      (mem_wr_addr),
        .wr_geom      (mem_wr_geom),
        .wr_rgb       (mem_wr_rgb),
        .geom_rd_en   (geom_rd_en),
        .geom_rd_addr (k_reg[ADDR_W-1:0]),
        .geom_rd      (geom_rd),
        .rgb_rd_en    (rgb_rd_en),
        .rgb_rd_addr  (best_k_reg[ADDR_W-1:0]),
        .rgb_rd       (rgb_rd)
    );

    rsnh_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    rsnh_isqrt u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (root_req),
        .rsp   (root_rsp)
    );

endmodule

`default_nettype wire

// ===== tb/ray_sphere_nearest_hit_unit_tb.sv =====
// Self-checking testbench of the ray and sphere nearest-hit unit with a bit-exact pixel predictor.
`timescale 1ns / 1ps

module ray_sphere_nearest_hit_unit_tb;

    // Clock, reset and the ports of the block. Every input has a known value from time 0.
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    rsnh_pkg::in_word_t in_word = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    rsnh_pkg::out_word_t out_word;
    logic cfg_we = 1'b0;
    logic [rsnh_pkg::CFG_INDEX_W-1:0] cfg_index = rsnh_pkg::CFG_EYE_X;
    logic [rsnh_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    localparam int TABLE_DEPTH = 8;
    localparam int IMG_H = 480;
    localparam int IN_W = $bits(rsnh_pkg::in_word_t);
    localparam longint ONE = 64'sd1 << rsnh_pkg::FRAC_BITS;
    // Enough cycles for a pixel tested against every table entry to finish, with margin.
    localparam int SETTLE_CYCLES = 800;

    ray_sphere_nearest_hit_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Words waiting to be sent, and the pixel results the block still owes us.
    rsnh_pkg::in_word_t  pending_words[$];
    rsnh_pkg::out_word_t expected_pixels[$];

    // Our own copy of the block's state: eye position, active count and the sphere table.
    longint eye_px, eye_py, eye_pz;
    int unsigned active_count;
    logic signed [rsnh_pkg::COORD_W-1:0] tbl_cx[TABLE_DEPTH];
    logic signed [rsnh_pkg::COORD_W-1:0] tbl_cy[TABLE_DEPTH];
    logic signed [rsnh_pkg::COORD_W-1:0] tbl_cz[TABLE_DEPTH];
    logic [rsnh_pkg::RADIUS_W-1:0] tbl_radius[TABLE_DEPTH];
    logic [rsnh_pkg::RGB_W-1:0] tbl_rgb[TABLE_DEPTH];

    int mismatch_count = 0;
    int pixels_checked = 0;
    int hits_seen = 0;
    int writes_sent = 0;
    int phases_run = 0;

    function automatic longint unsigned abs_val(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // Division rounded to nearest with halves away from zero; the divisor is positive.
    function automatic longint round_div(longint num, longint den);
        longint unsigned q;
        q = (abs_val(num) + longint'(den) / 2) / longint'(den);
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Drop the fraction bits of a product with the same rounding.
    function automatic longint round_drop(longint v);
        longint unsigned q;
        q = (abs_val(v) + (64'd1 << (rsnh_pkg::FRAC_BITS - 1))) >> rsnh_pkg::FRAC_BITS;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Floor integer square root, digit by digit.
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // Works out the colour, hit flag, index and distance that the block must give for a pixel.
    function automatic rsnh_pkg::out_word_t trace_pixel(rsnh_pkg::in_word_t w);
        rsnh_pkg::out_word_t r;
        longint px, py, rx, ry, rz, len, dx, dy, dz;
        longint ox, oy, oz, rad, h, cterm, disc, s, t, best_t;
        longint unsigned len2;
        int unsigned n, best_k;
        bit found;
        px = round_div((2 * longint'(w.pixel_x) + 1) * ONE, 2 * IMG_H);
        py = ONE - round_div((2 * longint'(w.pixel_y) + 1) * ONE, 2 * IMG_H);
        rx = px - eye_px;
        ry = py - eye_py;
        rz = -eye_pz;
        len2 = abs_val(rx) * abs_val(rx) + abs_val(ry) * abs_val(ry)
             + abs_val(rz) * abs_val(rz);
        len = longint'(floor_sqrt(len2));
        dx = 0;
        dy = 0;
        dz = 0;
        if (len != 0)
        begin
            dx = round_div(rx * ONE, len);
            dy = round_div(ry * ONE, len);
            dz = round_div(rz * ONE, len);
        end
        // An active count above the table size tests the whole table.
        n = (active_count > TABLE_DEPTH) ? TABLE_DEPTH : active_count;
        found = 1'b0;
        best_k = 0;
        best_t = 0;
        for (int unsigned k = 0; k < n; k++)
        begin
            ox = eye_px - longint'(tbl_cx[k]);
            oy = eye_py - longint'(tbl_cy[k]);
            oz = eye_pz - longint'(tbl_cz[k]);
            rad = longint'(tbl_radius[k]);
            h = round_drop(dx * ox + dy * oy + dz * oz);
            cterm = ox * ox + oy * oy + oz * oz - rad * rad;
            disc = h * h - cterm;
            if (disc < 0)
                continue;
            s = longint'(floor_sqrt(longint'(disc)));
            // Nearer root first; the farther one only when the eye sits inside the sphere.
            t = -h - s;
            if (t < 0)
                t = -h + s;
            if (t < 0)
                continue;
            // Strictly smaller wins, so on a tie the lower index stays.
            if (!found || t < best_t)
            begin
                found = 1'b1;
                best_t = t;
                best_k = k;
            end
        end
        if (found)
        begin
            r.pixel_red = tbl_rgb[best_k][23:16];
            r.pixel_green = tbl_rgb[best_k][15:8];
            r.pixel_blue = tbl_rgb[best_k][7:0];
            r.sphere_hit = 1'b1;
            r.hit_index = best_k[rsnh_pkg::INDEX_W-1:0];
            r.hit_distance = (best_t > 65535) ? 16'hFFFF : best_t[15:0];
        end
        else
        begin
            // Background: black when the ray points level or upward, white below.
            r.pixel_red = (ry >= 0) ? 8'd0 : 8'd255;
            r.pixel_green = r.pixel_red;
            r.pixel_blue = r.pixel_red;
            r.sphere_hit = 1'b0;
            r.hit_index = '0;
            r.hit_distance = '0;
        end
        return r;
    endfunction

    // A sphere write word; the pixel fields carry random noise that the block must ignore.
    function automatic rsnh_pkg::in_word_t sphere_word(int slot, logic [15:0] cx,
                                                       logic [15:0] cy, logic [15:0] cz,
                                                       logic [14:0] rad, logic [23:0] rgb);
        rsnh_pkg::in_word_t w;
        w.operation = rsnh_pkg::OP_WRITE;
        w.sphere_slot = slot[rsnh_pkg::SLOT_W-1:0];
        w.center_x = cx;
        w.center_y = cy;
        w.center_z = cz;
        w.radius = rad;
        {w.color_red, w.color_green, w.color_blue} = rgb;
        w.pixel_x = 10'($urandom);
        w.pixel_y = 9'($urandom);
        return w;
    endfunction

    // A pixel word; the sphere fields carry random noise.
    function automatic rsnh_pkg::in_word_t pixel_word(int x, int y);
        rsnh_pkg::in_word_t w;
        logic [127:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom};
        w = noise[IN_W-1:0];
        w.operation = rsnh_pkg::OP_TRACE;
        w.pixel_x = x[rsnh_pkg::PIX_X_W-1:0];
        w.pixel_y = y[rsnh_pkg::PIX_Y_W-1:0];
        return w;
    endfunction

    // A sphere that mostly sits in front of the eye, so that hits are common.
    function automatic rsnh_pkg::in_word_t random_sphere();
        if ($urandom_range(0, 3) == 0)
            return sphere_word($urandom_range(0, 7), 16'($urandom), 16'($urandom),
                               16'($urandom), 15'($urandom), 24'($urandom));
        return sphere_word($urandom_range(0, 7), 16'($urandom_range(0, 16384)),
                           16'($urandom_range(0, 16384)), 16'($urandom_range(0, 32767)),
                           15'($urandom_range(500, 12000)), 24'($urandom));
    endfunction

    // Sender: bursts of random length with random gaps; a stalled word is held as it is.
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                // The word is taken now: bring the table up to date or predict the pixel.
                if (in_word.operation == rsnh_pkg::OP_WRITE)
                begin
                    tbl_cx[in_word.sphere_slot] = in_word.center_x;
                    tbl_cy[in_word.sphere_slot] = in_word.center_y;
                    tbl_cz[in_word.sphere_slot] = in_word.center_z;
                    tbl_radius[in_word.sphere_slot] = in_word.radius;
                    tbl_rgb[in_word.sphere_slot] =
                        {in_word.color_red, in_word.color_green, in_word.color_blue};
                    writes_sent++;
                end
                else
                    expected_pixels.push_back(trace_pixel(in_word));
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_word <= pending_words.pop_front();
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each result against the oldest expectation, and stalls on a
    // pattern that switches between no stalls, light random stalls and long stalls.
    int stall_mode = 0;
    int mode_left = 50;
    int stall_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        rsnh_pkg::out_word_t exp_w;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word %h", out_word);
                end
                else
                begin
                    exp_w = expected_pixels.pop_front();
                    pixels_checked++;
                    if (exp_w.sphere_hit)
                        hits_seen++;
                    if (out_word.pixel_red !== exp_w.pixel_red
                        || out_word.pixel_green !== exp_w.pixel_green
                        || out_word.pixel_blue !== exp_w.pixel_blue
                        || out_word.sphere_hit !== exp_w.sphere_hit
                        || out_word.hit_index !== exp_w.hit_index
                        || out_word.hit_distance !== exp_w.hit_distance)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch at pixel %0d: expected rgb %h %h %h hit %b idx %0d dist %0d, got rgb %h %h %h hit %b idx %0d dist %0d",
                                     pixels_checked, exp_w.pixel_red, exp_w.pixel_green,
                                     exp_w.pixel_blue, exp_w.sphere_hit, exp_w.hit_index,
                                     exp_w.hit_distance, out_word.pixel_red,
                                     out_word.pixel_green, out_word.pixel_blue,
                                     out_word.sphere_hit, out_word.hit_index,
                                     out_word.hit_distance);
                    end
                end
            end
            mode_left--;
            if (mode_left <= 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 3000);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (stall_mode == 1)
                out_stall <= ($urandom_range(0, 3) == 0);
            else if (stall_mode == 2 && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(5, 60);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // One register write, made only while the block is idle; our copy follows it.
    task automatic write_reg(logic [rsnh_pkg::CFG_INDEX_W-1:0] idx,
                             logic [rsnh_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            rsnh_pkg::CFG_EYE_X:  eye_px = longint'($signed(val));
            rsnh_pkg::CFG_EYE_Y:  eye_py = longint'($signed(val));
            rsnh_pkg::CFG_EYE_Z:  eye_pz = longint'($signed(val));
            rsnh_pkg::CFG_ACTIVE: active_count = 32'(val[rsnh_pkg::ACTIVE_W-1:0]);
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every word is sent and every result has come.
    task automatic drain();
        while (pending_words.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_scene(logic [15:0] ex, logic [15:0] ey, logic [15:0] ez,
                             logic [3:0] act);
        drain();
        write_reg(rsnh_pkg::CFG_EYE_X, ex);
        write_reg(rsnh_pkg::CFG_EYE_Y, ey);
        write_reg(rsnh_pkg::CFG_EYE_Z, ez);
        write_reg(rsnh_pkg::CFG_ACTIVE, {12'd0, act});
        phases_run++;
    endtask

    initial
    begin
        eye_px = longint'(rsnh_pkg::EYE_X_RST);
        eye_py = longint'(rsnh_pkg::EYE_Y_RST);
        eye_pz = longint'(rsnh_pkg::EYE_Z_RST);
        active_count = 32'(rsnh_pkg::ACTIVE_RST);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset settings. Every slot is written first, so that no
        // pixel ever reads an entry that was never written.
        pending_words.push_back(sphere_word(0, 16'd8192, 16'd8192, 16'd16384, 15'd4096,
                                            24'hFF0000));
        pending_words.push_back(sphere_word(1, 16'd8192, 16'd8192, 16'd16384, 15'd4096,
                                            24'h00FF00));
        pending_words.push_back(sphere_word(2, 16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h7FFF,
                                            24'hFFFFFF));
        pending_words.push_back(sphere_word(3, 16'h8000, 16'h8000, 16'h8000, 15'd0,
                                            24'h000000));
        pending_words.push_back(sphere_word(4, 16'd8192, 16'd8192, 16'h8000, 15'd0,
                                            24'h123456));
        pending_words.push_back(sphere_word(5, 16'd0, 16'd0, 16'd0, 15'h7FFF, 24'hABCDEF));
        pending_words.push_back(sphere_word(6, 16'd8192, 16'd8192, 16'd0, 15'd8192,
                                            24'h0F0F0F));
        pending_words.push_back(sphere_word(7, 16'd8192, 16'd20000, 16'd16384, 15'd100,
                                            24'hF0F0F0));
        // Two identical spheres in slots 0 and 1 make a tie; slot 0 must win.
        pending_words.push_back(pixel_word(240, 240));
        pending_words.push_back(pixel_word(0, 0));
        pending_words.push_back(pixel_word(639, 479));
        pending_words.push_back(pixel_word(1023, 511));
        pending_words.push_back(pixel_word(0, 511));

        // All eight entries tested, including the sphere around the eye and the
        // zero-radius sphere straight behind the eye.
        set_scene(16'd8192, 16'd8192, 16'hC000, 4'd8);
        pending_words.push_back(pixel_word(240, 240));
        pending_words.push_back(pixel_word(1023, 0));
        pending_words.push_back(pixel_word(0, 479));

        // Tangent ray: a sphere whose edge just grazes the ray through the centre pixel.
        set_scene(16'd8192, 16'd8192, 16'hC000, 4'd1);
        pending_words.push_back(sphere_word(0, 16'd12288, 16'd8192, 16'd0, 15'd4096,
                                            24'h336699));
        pending_words.push_back(pixel_word(240, 240));
        pending_words.push_back(pixel_word(300, 240));

        // Eye placed on the image plane at the first pixel: a zero-length ray.
        set_scene(16'd17, 16'd16367, 16'd0, 4'd15);
        pending_words.push_back(pixel_word(0, 0));
        pending_words.push_back(pixel_word(1, 0));

        // Extreme eye positions, first with no active spheres, then with an active count above the table size.
        set_scene(16'h8000, 16'h8000, 16'h8000, 4'd0);
        pending_words.push_back(pixel_word(0, 0));
        pending_words.push_back(pixel_word(639, 479));
        set_scene(16'h7FFF, 16'h7FFF, 16'h7FFF, 4'd9);
        pending_words.push_back(pixel_word(639, 479));
        pending_words.push_back(pixel_word(0, 0));

        // Random part: each phase picks a new scene, then mixes table writes with pixels.
        for (int ph = 0; ph < 10; ph++)
        begin
            if ($urandom_range(0, 3) == 0)
                set_scene(16'($urandom), 16'($urandom), 16'($urandom),
                          4'($urandom_range(0, 15)));
            else
                set_scene(16'($urandom_range(0, 16384)), 16'($urandom_range(0, 16384)),
                          16'($signed(-$urandom_range(4000, 32768))),
                          4'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 15)
                                                         : $urandom_range(1, 4)));
            for (int i = 0; i < 128; i++)
            begin
                if ($urandom_range(0, 9) < 4)
                    pending_words.push_back(random_sphere());
                else if ($urandom_range(0, 4) == 0)
                    pending_words.push_back(pixel_word($urandom_range(0, 1023),
                                                       $urandom_range(0, 511)));
                else
                    pending_words.push_back(pixel_word($urandom_range(0, 639),
                                                       $urandom_range(0, 479)));
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_pixels.size() != 0)
            mismatch_count += expected_pixels.size();
        $display("covered %0d scene settings, %0d sphere writes, %0d pixels checked (%0d hits)",
                 phases_run, writes_sent, pixels_checked, hits_seen);
        $display("mismatches: %0d", mismatch_count);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial
    begin
        #100ms;
        $display("timeout waiting for the block");
        $display("simulation failed");
        $finish;
    end

endmodule
